// ===== design/a429_pkg.sv =====
package a429_pkg;

    localparam int WORD_W  = 32;
    localparam int VALUE_W = 39;
    localparam int FIELD_W = 21;
    localparam int PROD_W  = 44;

    localparam logic [2:0] STATUS_PARITY_ERR = 3'd0;
    localparam logic [2:0] STATUS_NOT_USED   = 3'd1;
    localparam logic [2:0] STATUS_SSM_BASE   = 3'd2;

    localparam logic [2:0] HEMI_NONE  = 3'd0;
    localparam logic [2:0] HEMI_NORTH = 3'd1;
    localparam logic [2:0] HEMI_SOUTH = 3'd2;
    localparam logic [2:0] HEMI_EAST  = 3'd3;
    localparam logic [2:0] HEMI_WEST  = 3'd4;

    localparam logic [1:0] ENG_NONE  = 2'd0;
    localparam logic [1:0] ENG_LEFT  = 2'd1;
    localparam logic [1:0] ENG_RIGHT = 2'd2;

    localparam logic [1:0] SDI_LEFT  = 2'b01;
    localparam logic [1:0] SDI_RIGHT = 2'b10;

    localparam logic [22:0] MACH_MULT  = 23'd4294967;
    localparam logic [6:0]  MULT_45    = 7'd45;
    localparam int          MACH_SHIFT = 16;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_LAT,
        KIND_LON,
        KIND_ENGINE
    } kind_t;

    typedef enum logic [1:0] {
        SCALE_ONE,
        SCALE_45,
        SCALE_MACH
    } scale_t;

    typedef struct packed {
        logic        hit;
        logic [4:0]  id;
        logic [3:0]  fshift;
        kind_t       kind;
        scale_t      scale;
        logic [4:0]  lsh;
    } entry_t;

    typedef struct packed {
        logic [1:0]         engine_side;
        logic [2:0]         hemisphere;
        logic [VALUE_W-1:0] value_q20;
        logic [4:0]         parameter_id;
        logic [7:0]         label_octal;
        logic [2:0]         status_code;
    } result_t;

    function automatic entry_t mk(input logic [4:0] id, input logic [4:0] bits,
                                  input kind_t kind, input scale_t scale,
                                  input logic [4:0] lsh);
        entry_t e;
        e.hit    = 1'b1;
        e.id     = id;
        e.fshift = 4'(5'd20 - bits);
        e.kind   = kind;
        e.scale  = scale;
        e.lsh    = lsh;
        return e;
    endfunction

    function automatic entry_t label_lookup(input logic [7:0] lab);
        entry_t e;
        e = '0;
        case (lab)
            8'h61:   e = mk(5'd1,  5'd14, KIND_PLAIN,  SCALE_ONE,  5'd16);
            8'h75:   e = mk(5'd2,  5'd14, KIND_PLAIN,  SCALE_ONE,  5'd16);
            8'h11:   e = mk(5'd3,  5'd15, KIND_PLAIN,  SCALE_ONE,  5'd16);
            8'h53:   e = mk(5'd4,  5'd15, KIND_PLAIN,  SCALE_ONE,  5'd17);
            8'hA1:   e = mk(5'd5,  5'd16, KIND_PLAIN,  SCALE_MACH, 5'd0);
            8'hAF:   e = mk(5'd6,  5'd15, KIND_PLAIN,  SCALE_ONE,  5'd20);
            8'h89:   e = mk(5'd7,  5'd12, KIND_PLAIN,  SCALE_45,   5'd10);
            8'h15:   e = mk(5'd8,  5'd12, KIND_PLAIN,  SCALE_45,   5'd10);
            8'h2B:   e = mk(5'd9,  5'd14, KIND_PLAIN,  SCALE_45,   5'd8);
            8'hAB:   e = mk(5'd10, 5'd14, KIND_PLAIN,  SCALE_45,   5'd8);
            8'h33:   e = mk(5'd11, 5'd15, KIND_PLAIN,  SCALE_45,   5'd7);
            8'h0B:   e = mk(5'd12, 5'd15, KIND_PLAIN,  SCALE_45,   5'd7);
            8'h13:   e = mk(5'd13, 5'd20, KIND_LAT,    SCALE_45,   5'd2);
            8'h93:   e = mk(5'd14, 5'd20, KIND_LON,    SCALE_45,   5'd2);
            8'hC1:   e = mk(5'd15, 5'd17, KIND_PLAIN,  SCALE_ONE,  5'd20);
            8'h54:   e = mk(5'd16, 5'd15, KIND_PLAIN,  SCALE_ONE,  5'd11);
            8'hD4:   e = mk(5'd17, 5'd15, KIND_PLAIN,  SCALE_ONE,  5'd11);
            8'h34:   e = mk(5'd18, 5'd15, KIND_PLAIN,  SCALE_ONE,  5'd11);
            8'h6B:   e = mk(5'd19, 5'd13, KIND_PLAIN,  SCALE_ONE,  5'd14);
            8'hEB:   e = mk(5'd20, 5'd13, KIND_PLAIN,  SCALE_ONE,  5'd14);
            8'h1B:   e = mk(5'd21, 5'd13, KIND_PLAIN,  SCALE_ONE,  5'd14);
            8'h91:   e = mk(5'd22, 5'd12, KIND_PLAIN,  SCALE_ONE,  5'd17);
            8'hD1:   e = mk(5'd23, 5'd11, KIND_PLAIN,  SCALE_ONE,  5'd18);
            8'hF1:   e = mk(5'd24, 5'd16, KIND_PLAIN,  SCALE_ONE,  5'd10);
            8'h47:   e = mk(5'd25, 5'd12, KIND_PLAIN,  SCALE_ONE,  5'd10);
            8'h07:   e = mk(5'd26, 5'd12, KIND_ENGINE, SCALE_ONE,  5'd10);
            8'hE7:   e = mk(5'd27, 5'd12, KIND_ENGINE, SCALE_ONE,  5'd23);
            8'hA7:   e = mk(5'd28, 5'd12, KIND_ENGINE, SCALE_ONE,  5'd19);
            8'hF3:   e = mk(5'd29, 5'd12, KIND_ENGINE, SCALE_ONE,  5'd20);
            8'h73:   e = mk(5'd30, 5'd12, KIND_ENGINE, SCALE_ONE,  5'd19);
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ===== design/a429_decode.sv =====
module a429_decode (
    input  logic [a429_pkg::WORD_W-1:0] word,
    output a429_pkg::result_t           res
);

    a429_pkg::entry_t                    entry;
    logic                                parity_ok;
    logic [7:0]                          label_rev;
    logic signed [a429_pkg::FIELD_W-1:0] raw;
    logic signed [a429_pkg::FIELD_W:0]   raw_ext;
    logic signed [a429_pkg::FIELD_W:0]   mag_wide;
    logic [a429_pkg::FIELD_W-1:0]        mag;
    logic                                neg;
    logic [a429_pkg::PROD_W-1:0]         prod;
    logic [a429_pkg::VALUE_W-1:0]        vmag;

    assign entry     = a429_pkg::label_lookup(word[7:0]);
    assign parity_ok = ^word;
    assign neg       = word[28];
    assign raw       = $signed(word[28:8]) >>> entry.fshift;
    assign raw_ext   = {raw[a429_pkg::FIELD_W-1], raw};
    assign mag_wide  = neg ? -raw_ext : raw_ext;
    assign mag       = mag_wide[a429_pkg::FIELD_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            label_rev[i] = word[7-i];
        end
    end

    always_comb
    begin
        case (entry.scale)
            a429_pkg::SCALE_ONE:  prod = a429_pkg::PROD_W'(mag);
            a429_pkg::SCALE_45:   prod = a429_pkg::PROD_W'(mag) * a429_pkg::MULT_45;
            a429_pkg::SCALE_MACH: prod = a429_pkg::PROD_W'(mag) * a429_pkg::MACH_MULT;
            default:              prod = '0;
        endcase
    end

    always_comb
    begin
        if (entry.scale == a429_pkg::SCALE_MACH)
        begin
            vmag = a429_pkg::VALUE_W'(prod >> a429_pkg::MACH_SHIFT);
        end
        else
        begin
            vmag = a429_pkg::VALUE_W'(prod) << entry.lsh;
        end
    end

    always_comb
    begin
        res = '0;
        if (parity_ok)
        begin
            res.label_octal = label_rev;
            if (!entry.hit)
            begin
                res.status_code = a429_pkg::STATUS_NOT_USED;
            end
            else
            begin
                res.status_code  = a429_pkg::STATUS_SSM_BASE + 3'(word[30:29]);
                res.parameter_id = entry.id;
                case (entry.kind)
                    a429_pkg::KIND_LAT:
                    begin
                        res.value_q20  = vmag;
                        res.hemisphere = neg ? a429_pkg::HEMI_SOUTH : a429_pkg::HEMI_NORTH;
                    end
                    a429_pkg::KIND_LON:
                    begin
                        res.value_q20  = vmag;
                        res.hemisphere = neg ? a429_pkg::HEMI_WEST : a429_pkg::HEMI_EAST;
                    end
                    default:
                    begin
                        res.value_q20 = neg ? (a429_pkg::VALUE_W'(0) - vmag) : vmag;
                    end
                endcase
                if (entry.kind == a429_pkg::KIND_ENGINE)
                begin
                    case (word[9:8])
                        a429_pkg::SDI_LEFT:  res.engine_side = a429_pkg::ENG_LEFT;
                        a429_pkg::SDI_RIGHT: res.engine_side = a429_pkg::ENG_RIGHT;
                        default:             res.engine_side = a429_pkg::ENG_NONE;
                    endcase
                end
            end
        end
    end

endmodule

// ===== design/arinc429_bnr_word_decoder_top.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   32     word
// m_axis    out  64     status, label, parameter id, Q20 value, hemisphere, engine side
//
// A word passes from input beat to result beat through the input register, then
// one pass of lookup, constant multiply and shift into the result register.
// One word per cycle is sustained while m_tready stays high.
// rst_n clears both valid flags; payload registers are not reset.
// A stall on m_tready holds the result and lets the input register fill once.
module arinc429_bnr_word_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [2:0] status_code, [10:3] label_octal,
                                   // [15:11] parameter_id, [54:16] value_q20,
                                   // [57:55] hemisphere, [59:58] engine_side,
                                   // [63:60] zero
);

    logic                          in_valid_reg;
    logic [a429_pkg::WORD_W-1:0]   word_reg;
    logic                          out_valid_reg;
    a429_pkg::result_t             res_reg;
    a429_pkg::result_t             res_next;
    logic                          advance;

    a429_decode u_decode (
        .word (word_reg),
        .res  (res_next)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            word_reg <= s_tdata;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== tb/sv/arinc429_bnr_word_decoder_top_test.sv =====
module arinc429_bnr_word_decoder_top_test;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 550;
    localparam int TAIL_CYCLES = 8;

    localparam bit [7:0] KNOWN_LABELS [30] = '{
        8'h61, 8'h75, 8'h11, 8'h53, 8'hA1, 8'hAF, 8'h89, 8'h15, 8'h2B, 8'hAB,
        8'h33, 8'h0B, 8'h13, 8'h93, 8'hC1, 8'h54, 8'hD4, 8'h34, 8'h6B, 8'hEB,
        8'h1B, 8'h91, 8'hD1, 8'hF1, 8'h47, 8'h07, 8'hE7, 8'hA7, 8'hF3, 8'h73
    };

    class a429_decode_scoreboard;

        localparam bit [63:0] Q20_ONE = 64'd1 << 20;

        typedef struct {
            bit [4:0]        id;
            int              bits;
            a429_pkg::kind_t kind;
            bit [63:0]       range_q20;
        } label_rec_t;

        a429_pkg::result_t pending_results[$];
        int                mismatches;

        function new();
            mismatches = 0;
        endfunction

        function label_rec_t rec(bit [4:0] id, int bits, a429_pkg::kind_t kind,
                                 bit [63:0] range_q20);
            label_rec_t r;
            r.id        = id;
            r.bits      = bits;
            r.kind      = kind;
            r.range_q20 = range_q20;
            return r;
        endfunction

        function label_rec_t label_info(bit [7:0] lab);
            label_rec_t r;
            r = rec(5'd0, 0, a429_pkg::KIND_PLAIN, 64'd0);
            case (lab)
                8'h61: r = rec(5'd1,  14, a429_pkg::KIND_PLAIN,  1024 * Q20_ONE);
                8'h75: r = rec(5'd2,  14, a429_pkg::KIND_PLAIN,  1024 * Q20_ONE);
                8'h11: r = rec(5'd3,  15, a429_pkg::KIND_PLAIN,  2048 * Q20_ONE);
                8'h53: r = rec(5'd4,  15, a429_pkg::KIND_PLAIN,  4096 * Q20_ONE);
                8'hA1: r = rec(5'd5,  16, a429_pkg::KIND_PLAIN,  64'd4294967);
                8'hAF: r = rec(5'd6,  15, a429_pkg::KIND_PLAIN,  32768 * Q20_ONE);
                8'h89: r = rec(5'd7,  12, a429_pkg::KIND_PLAIN,  180 * Q20_ONE);
                8'h15: r = rec(5'd8,  12, a429_pkg::KIND_PLAIN,  180 * Q20_ONE);
                8'h2B: r = rec(5'd9,  14, a429_pkg::KIND_PLAIN,  180 * Q20_ONE);
                8'hAB: r = rec(5'd10, 14, a429_pkg::KIND_PLAIN,  180 * Q20_ONE);
                8'h33: r = rec(5'd11, 15, a429_pkg::KIND_PLAIN,  180 * Q20_ONE);
                8'h0B: r = rec(5'd12, 15, a429_pkg::KIND_PLAIN,  180 * Q20_ONE);
                8'h13: r = rec(5'd13, 20, a429_pkg::KIND_LAT,    180 * Q20_ONE);
                8'h93: r = rec(5'd14, 20, a429_pkg::KIND_LON,    180 * Q20_ONE);
                8'hC1: r = rec(5'd15, 17, a429_pkg::KIND_PLAIN,  131072 * Q20_ONE);
                8'h54: r = rec(5'd16, 15, a429_pkg::KIND_PLAIN,  64 * Q20_ONE);
                8'hD4: r = rec(5'd17, 15, a429_pkg::KIND_PLAIN,  64 * Q20_ONE);
                8'h34: r = rec(5'd18, 15, a429_pkg::KIND_PLAIN,  64 * Q20_ONE);
                8'h6B: r = rec(5'd19, 13, a429_pkg::KIND_PLAIN,  128 * Q20_ONE);
                8'hEB: r = rec(5'd20, 13, a429_pkg::KIND_PLAIN,  128 * Q20_ONE);
                8'h1B: r = rec(5'd21, 13, a429_pkg::KIND_PLAIN,  128 * Q20_ONE);
                8'h91: r = rec(5'd22, 12, a429_pkg::KIND_PLAIN,  512 * Q20_ONE);
                8'hD1: r = rec(5'd23, 11, a429_pkg::KIND_PLAIN,  512 * Q20_ONE);
                8'hF1: r = rec(5'd24, 16, a429_pkg::KIND_PLAIN,  64 * Q20_ONE);
                8'h47: r = rec(5'd25, 12, a429_pkg::KIND_PLAIN,  4 * Q20_ONE);
                8'h07: r = rec(5'd26, 12, a429_pkg::KIND_ENGINE, 4 * Q20_ONE);
                8'hE7: r = rec(5'd27, 12, a429_pkg::KIND_ENGINE, 32768 * Q20_ONE);
                8'hA7: r = rec(5'd28, 12, a429_pkg::KIND_ENGINE, 2048 * Q20_ONE);
                8'hF3: r = rec(5'd29, 12, a429_pkg::KIND_ENGINE, 4096 * Q20_ONE);
                8'h73: r = rec(5'd30, 12, a429_pkg::KIND_ENGINE, 2048 * Q20_ONE);
                default: r.id = 5'd0;
            endcase
            return r;
        endfunction

        function a429_pkg::result_t decode_word(bit [31:0] w);
            a429_pkg::result_t r;
            label_rec_t        info;
            bit [63:0]         field;
            bit [63:0]         mag;
            bit [63:0]         vmag;
            bit [63:0]         value;
            bit                neg;
            r = '0;
            if (^w == 1'b0)
                return r;
            for (int i = 0; i < 8; i++)
                r.label_octal[i] = w[7 - i];
            info = label_info(w[7:0]);
            if (info.id == 5'd0)
            begin
                r.status_code = a429_pkg::STATUS_NOT_USED;
                return r;
            end
            r.status_code  = a429_pkg::STATUS_SSM_BASE + 3'(w[30:29]);
            r.parameter_id = info.id;
            field = (64'(w) >> (28 - info.bits)) & ((64'd1 << (info.bits + 1)) - 64'd1);
            neg   = field[info.bits];
            mag   = neg ? (64'd1 << (info.bits + 1)) - field : field;
            vmag  = (info.range_q20 * mag) >> info.bits;
            value = vmag;
            case (info.kind)
                a429_pkg::KIND_LAT:
                    r.hemisphere = neg ? a429_pkg::HEMI_SOUTH : a429_pkg::HEMI_NORTH;
                a429_pkg::KIND_LON:
                    r.hemisphere = neg ? a429_pkg::HEMI_WEST : a429_pkg::HEMI_EAST;
                default:  value = neg ? (64'd0 - vmag) : vmag;
            endcase
            r.value_q20 = value[a429_pkg::VALUE_W-1:0];
            if (info.kind == a429_pkg::KIND_ENGINE)
            begin
                if (w[9:8] == a429_pkg::SDI_LEFT)
                    r.engine_side = a429_pkg::ENG_LEFT;
                else if (w[9:8] == a429_pkg::SDI_RIGHT)
                    r.engine_side = a429_pkg::ENG_RIGHT;
            end
            return r;
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            mismatches++;
        endtask

        function void note_word(bit [31:0] w);
            pending_results.push_back(decode_word(w));
        endfunction

        task check_result(bit [63:0] beat);
            a429_pkg::result_t got;
            a429_pkg::result_t want;
            got = beat[59:0];
            if (pending_results.size() == 0)
            begin
                report("unexpected beat", beat, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.status_code != want.status_code)
                report("status_code", got.status_code, want.status_code);
            if (got.label_octal != want.label_octal)
                report("label_octal", got.label_octal, want.label_octal);
            if (got.parameter_id != want.parameter_id)
                report("parameter_id", got.parameter_id, want.parameter_id);
            if (got.value_q20 != want.value_q20)
                report("value_q20", got.value_q20, want.value_q20);
            if (got.hemisphere != want.hemisphere)
                report("hemisphere", got.hemisphere, want.hemisphere);
            if (got.engine_side != want.engine_side)
                report("engine_side", got.engine_side, want.engine_side);
            if (beat[63:60] != 4'd0)
                report("pad bits", beat[63:60], 0);
        endtask

    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        steady = 1'b0;

    a429_decode_scoreboard decode_sb = new();

    arinc429_bnr_word_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit [31:0] seal(bit [31:0] w, bit good);
        bit [31:0] r;
        r = w;
        r[31] = good ? ~(^w[30:0]) : ^w[30:0];
        return r;
    endfunction

    function automatic bit [31:0] random_word();
        bit [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 99) < 75)
            w[7:0] = KNOWN_LABELS[$urandom_range(0, 29)];
        case ($urandom_range(0, 9))
            0: w[28:8] = 21'h100000;
            1: w[28:8] = 21'h0FFFFF;
            2: w[28:8] = 21'h1FFFFF;
            3: w[28:8] = 21'h000000;
            default: ;
        endcase
        return seal(w, $urandom_range(0, 99) >= 12);
    endfunction

    task send_word(bit [31:0] w);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < 25)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 25);

    // score beats on the edge at which they are accepted
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            decode_sb.note_word(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            decode_sb.check_result(m_tdata);
    end

    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        bit [31:0] directed [$];
        directed = {
            32'h0000_0000,
            32'hFFFF_FFFF,
            seal(32'h0000_0000, 1'b1),
            seal(32'h7FFF_FFFF, 1'b1),
            seal(32'h6FFF_FF13, 1'b1),
            seal(32'h7000_0013, 1'b1),
            seal(32'h7FFF_FF93, 1'b1),
            seal(32'h6000_0093, 1'b1),
            seal(32'h7000_00A1, 1'b1),
            seal(32'h6FFF_F0A1, 1'b1),
            seal(32'h6FFF_E0AF, 1'b1),
            seal(32'h7000_00C1, 1'b1),
            seal(32'h6123_4007, 1'b1),
            seal(32'h6123_4107, 1'b1),
            seal(32'h6123_4207, 1'b1),
            seal(32'h6123_4307, 1'b1),
            seal(32'h0ABC_D061, 1'b1),
            seal(32'h2ABC_D061, 1'b1),
            seal(32'h4ABC_D061, 1'b1),
            seal(32'h6ABC_D061, 1'b1),
            seal(32'h7800_02E7, 1'b1),
            seal(32'h6ABC_D061, 1'b0),
            seal(32'h5555_5300, 1'b1),
            seal(32'h3AAA_AAFE, 1'b1)
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_word(directed[i]);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            steady <= (n >= 250 && n < 370);
            send_word(random_word());
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;
        while (decode_sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (decode_sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/a429_pkg.sv
design/a429_decode.sv
design/arinc429_bnr_word_decoder_top.sv
tb/sv/arinc429_bnr_word_decoder_top_test.sv
